[rtl/core/cte_pkg.sv]
package cte_pkg;

  // Field widths of the channel items
  localparam int YearW   = 13;
  localparam int MonthW  = 8;
  localparam int DayW    = 5;
  localparam int HourW   = 5;
  localparam int MinuteW = 6;
  localparam int SecondW = 6;
  localparam int EpochW  = 39;

  // Internal widths
  localparam int FullYearW = 14;  // folded calendar year, 1889..10101
  localparam int DayCountW = 23;  // signed days since the epoch
  localparam int HmsW      = 17;  // seconds within the day, unchecked fields
  localparam int Q100W     = 8;   // floor((year-1)/100)

  // Month fold: bias the month by 11 years so the quotient is never negative
  localparam logic [8:0]  MonthBias  = 9'd132;
  localparam logic [15:0] Recip12    = 16'd171;   // 171/2^11 ~ 1/12
  localparam int          Recip12Sh  = 11;
  // 1900 - 11 years of month bias
  localparam logic [FullYearW-1:0] YearBase = 14'd1889;

  // p / 100 by reciprocal: 5243/2^19 ~ 1/100, exact for p below 2^14
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam int          Recip100Sh = 19;

  // Days from 0001-01-01 to 1970-01-01
  localparam logic [DayCountW-1:0] EpochDays = 23'd719162;
  localparam logic signed [17:0]   SecsPerDay = 18'sd86400;

  // Days before each month, common and leap years
  localparam logic [8:0] DbmCommon [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
    9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
  };
  localparam logic [8:0] DbmLeap [12] = '{
    9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
    9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
  };

  // One accepted input beat
  typedef struct packed {
    logic [YearW-1:0]         years_since_1900;
    logic signed [MonthW-1:0] month_index;
    logic [DayW-1:0]          day_of_month;
    logic [HourW-1:0]         hour;
    logic [MinuteW-1:0]       minute;
    logic [SecondW-1:0]       second;
  } cte_req_t;

  // After the month fold
  typedef struct packed {
    logic [FullYearW-1:0] year;
    logic [3:0]           month;
    logic [DayW-1:0]      day;
    logic [HourW-1:0]     hour;
    logic [MinuteW-1:0]   minute;
    logic [SecondW-1:0]   second;
  } cte_fold_t;

  // Day count and time of day
  typedef struct packed {
    logic signed [DayCountW-1:0] days;
    logic [HmsW-1:0]             hms;
  } cte_days_t;

  typedef struct packed {
    logic [4:0] years;  // biased year offset, 0..21
    logic [3:0] month;  // 0..11
  } cte_mfold_t;

  // Floor-divide the signed month by 12
  function automatic cte_mfold_t fold_month(logic signed [MonthW-1:0] m);
    logic [8:0]  mb;
    logic [15:0] prod;
    logic [4:0]  q;
    logic [8:0]  rem;
    cte_mfold_t  res;
    mb   = {m[MonthW-1], m} + MonthBias;
    prod = 16'(mb) * Recip12;
    q    = prod[Recip12Sh+4:Recip12Sh];
    rem  = mb - 9'(q) * 9'd12;
    res.years = q;
    res.month = rem[3:0];
    return res;
  endfunction

endpackage

[rtl/core/cte_in_if.sv]
interface cte_in_if;
  import cte_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [YearW-1:0]         years_since_1900;
  logic signed [MonthW-1:0] month_index;
  logic [DayW-1:0]          day_of_month;
  logic [HourW-1:0]         hour;
  logic [MinuteW-1:0]       minute;
  logic [SecondW-1:0]       second;

  modport source (
    output valid, years_since_1900, month_index, day_of_month, hour, minute, second,
    input  ready
  );
  modport sink (
    input  valid, years_since_1900, month_index, day_of_month, hour, minute, second,
    output ready
  );
endinterface

[rtl/core/cte_out_if.sv]
interface cte_out_if;
  import cte_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [EpochW-1:0] epoch_seconds;

  modport source (output valid, epoch_seconds, input ready);
  modport sink (input valid, epoch_seconds, output ready);
endinterface

[rtl/core/cte_month_fold.sv]
module cte_month_fold
  import cte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s_valid,
  output logic      s_ready,
  input  cte_req_t  s_data,
  output logic      m_valid,
  input  logic      m_ready,
  output cte_fold_t m_data
);

  logic       v_r;
  logic       en;
  cte_fold_t  data_r;
  cte_fold_t  data_nxt;
  cte_mfold_t mf;

  // stage moves when empty or when downstream takes the beat
  assign en      = !v_r || m_ready;
  assign s_ready = en;

  // fold month into year
  always_comb begin
    mf              = fold_month(s_data.month_index);
    data_nxt.year   = FullYearW'(s_data.years_since_1900) + YearBase + FullYearW'(mf.years);
    data_nxt.month  = mf.month;
    data_nxt.day    = s_data.day_of_month;
    data_nxt.hour   = s_data.hour;
    data_nxt.minute = s_data.minute;
    data_nxt.second = s_data.second;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && s_valid) begin
      data_r <= data_nxt;
    end
  end

  assign m_valid = v_r;
  assign m_data  = data_r;

endmodule

[rtl/core/cte_year_days.sv]
module cte_year_days
  import cte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      s_valid,
  output logic      s_ready,
  input  cte_fold_t s_data,
  output logic      m_valid,
  input  logic      m_ready,
  output cte_days_t m_data
);

  // stage A: p = year-1 and p/100
  logic                 va_r;
  logic                 en_a;
  logic [FullYearW-1:0] p_r;
  logic [FullYearW-1:0] p_nxt;
  logic [Q100W-1:0]     q100_r;
  logic [Q100W-1:0]     q100_nxt;
  logic [26:0]          q100_prod;
  cte_fold_t            fa_r;

  // stage B: leap rule, day count, time of day
  logic                 vb_r;
  logic                 en_b;
  cte_days_t            db_r;
  cte_days_t            db_nxt;
  logic [5:0]           q400;
  logic [FullYearW-1:0] r100;
  logic [FullYearW-1:0] r400;
  logic                 leap;
  logic [8:0]           dbm;
  logic [DayCountW-1:0] day_sum;

  assign en_b    = !vb_r || m_ready;
  assign en_a    = !va_r || en_b;
  assign s_ready = en_a;

  // reciprocal divide by 100
  always_comb begin
    p_nxt     = s_data.year - FullYearW'(1);
    q100_prod = 27'(p_nxt) * 27'(Recip100);
    q100_nxt  = q100_prod[Recip100Sh+Q100W-1:Recip100Sh];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en_a) begin
      va_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && s_valid) begin
      p_r    <= p_nxt;
      q100_r <= q100_nxt;
      fa_r   <= s_data;
    end
  end

  // year % 400 == 0 <=> p % 400 == 399, likewise for 100 and 4
  always_comb begin
    q400 = q100_r[Q100W-1:2];
    r100 = p_r - FullYearW'(q100_r) * FullYearW'(100);
    r400 = p_r - FullYearW'(q400) * FullYearW'(400);
    leap = (r400 == FullYearW'(399)) ||
           ((r100 != FullYearW'(99)) && (p_r[1:0] == 2'b11));
    dbm  = leap ? DbmLeap[fa_r.month] : DbmCommon[fa_r.month];
    // two's complement sum, true value fits the signed width
    day_sum = DayCountW'(p_r) * DayCountW'(365) + DayCountW'(p_r >> 2)
            + DayCountW'(q400) - DayCountW'(q100_r) - EpochDays
            + DayCountW'(dbm) + DayCountW'(fa_r.day) - DayCountW'(1);
    db_nxt.days = $signed(day_sum);
    db_nxt.hms  = HmsW'(fa_r.hour) * HmsW'(3600) + HmsW'(fa_r.minute) * HmsW'(60)
                + HmsW'(fa_r.second);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && va_r) begin
      db_r <= db_nxt;
    end
  end

  assign m_valid = vb_r;
  assign m_data  = db_r;

endmodule

[rtl/core/cte_sec_scale.sv]
module cte_sec_scale
  import cte_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     s_valid,
  output logic                     s_ready,
  input  cte_days_t                s_data,
  output logic                     m_valid,
  input  logic                     m_ready,
  output logic signed [EpochW-1:0] m_secs
);

  // stage A: days * 86400
  logic                     va_r;
  logic                     en_a;
  logic signed [EpochW:0]   prod;
  logic signed [EpochW-1:0] prod_r;
  logic [HmsW-1:0]          hms_r;

  // stage B: add time of day, output register
  logic                     vb_r;
  logic                     en_b;
  logic signed [EpochW-1:0] secs_r;
  logic signed [EpochW-1:0] secs_nxt;

  assign en_b    = !vb_r || m_ready;
  assign en_a    = !va_r || en_b;
  assign s_ready = en_a;

  assign prod = s_data.days * SecsPerDay;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en_a) begin
      va_r <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && s_valid) begin
      prod_r <= prod[EpochW-1:0];
      hms_r  <= s_data.hms;
    end
  end

  assign secs_nxt = prod_r + $signed({{(EpochW-HmsW){1'b0}}, hms_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en_b) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en_b && va_r) begin
      secs_r <= secs_nxt;
    end
  end

  assign m_valid = vb_r;
  assign m_secs  = secs_r;

endmodule

[rtl/core/calendar_to_epoch_seconds_unit.sv]
// Calendar to epoch seconds.
// in_ch carries one broken-down UTC date and time per beat (years since
// 1900, signed zero-based month, day, hour, minute, second); out_ch carries
// the signed 39-bit seconds since 1970-01-01 00:00:00 for that beat.
// A month outside 0..11 is folded into the year first.
// Five register stages: month fold, divide by 100, leap rule and day count,
// scale by 86400, add time of day. One beat enters every cycle while
// out_ch.ready keeps the pipeline moving, since every stage takes a new
// beat on each cycle that it advances.
// Every stage holds its own valid bit and advances when it is empty or the
// next stage moves, so when out_ch.ready is low the output beat holds, the
// stages behind it fill their bubbles, and in_ch.ready drops only once all
// five stages are full. Nothing is lost or repeated under stalls.
// Reset (rst_n low, synchronous) empties the pipeline; there is no other
// state and no configuration.
module calendar_to_epoch_seconds_unit
  import cte_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  cte_in_if.sink    in_ch,
  cte_out_if.source out_ch
);

  cte_req_t  req;
  cte_fold_t fold_data;
  cte_days_t days_data;
  logic      fold_valid;
  logic      fold_ready;
  logic      days_valid;
  logic      days_ready;

  // pack the input beat
  always_comb begin
    req.years_since_1900 = in_ch.years_since_1900;
    req.month_index      = in_ch.month_index;
    req.day_of_month     = in_ch.day_of_month;
    req.hour             = in_ch.hour;
    req.minute           = in_ch.minute;
    req.second           = in_ch.second;
  end

  cte_month_fold u_fold (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (in_ch.valid),
    .s_ready (in_ch.ready),
    .s_data  (req),
    .m_valid (fold_valid),
    .m_ready (fold_ready),
    .m_data  (fold_data)
  );

  cte_year_days u_days (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (fold_valid),
    .s_ready (fold_ready),
    .s_data  (fold_data),
    .m_valid (days_valid),
    .m_ready (days_ready),
    .m_data  (days_data)
  );

  cte_sec_scale u_secs (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (days_valid),
    .s_ready (days_ready),
    .s_data  (days_data),
    .m_valid (out_ch.valid),
    .m_ready (out_ch.ready),
    .m_secs  (out_ch.epoch_seconds)
  );

endmodule

[sim/epoch_seconds_checker.sv]
module epoch_seconds_checker
  import cte_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cte_in_if           in_ch,
  cte_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Days before each month, common and leap years
  int days_before_common[12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
  int days_before_leap[12]   = '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335};

  logic signed [EpochW-1:0] expected_epochs[$];
  int unsigned              mismatches;

  // Days from 0001-01-01 to Jan 1 of the given year
  function automatic longint days_from_year_one(longint yr);
    longint p;
    p = yr - 1;
    return 365 * p + p / 400 - p / 100 + p / 4;
  endfunction

  // Broken-down UTC date to seconds since 1970-01-01
  function automatic logic signed [EpochW-1:0] civil_to_epoch(cte_req_t d);
    longint yr;
    longint mon;
    longint back;
    longint days;
    longint secs;
    bit     leap;
    yr  = longint'(d.years_since_1900) + 1900;
    mon = longint'($signed(d.month_index));
    // fold an out-of-range month into the year
    if (mon > 11) begin
      yr  = yr + mon / 12;
      mon = mon % 12;
    end else if (mon < 0) begin
      back = (11 - mon) / 12;
      yr   = yr - back;
      mon  = mon + 12 * back;
    end
    leap = (yr % 400 == 0) || ((yr % 100 != 0) && (yr % 4 == 0));
    days = days_from_year_one(yr) - days_from_year_one(1970)
         + (leap ? days_before_leap[mon] : days_before_common[mon])
         + longint'(d.day_of_month) - 1;
    secs = days * 86400 + 3600 * longint'(d.hour) + 60 * longint'(d.minute)
         + longint'(d.second);
    return secs[EpochW-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] epoch mismatch: %s", $time, msg);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    fail_count = 0;
    pending    = 0;
  end

  // Sample both channels on the clock edge; drivers update with NBAs
  always @(posedge clk) begin
    cte_req_t                 d;
    logic signed [EpochW-1:0] want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        d.years_since_1900 = in_ch.years_since_1900;
        d.month_index      = in_ch.month_index;
        d.day_of_month     = in_ch.day_of_month;
        d.hour             = in_ch.hour;
        d.minute           = in_ch.minute;
        d.second           = in_ch.second;
        expected_epochs.push_back(civil_to_epoch(d));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_epochs.size() == 0) begin
          report_mismatch($sformatf("unexpected beat %0d", out_ch.epoch_seconds));
        end else begin
          want = expected_epochs.pop_front();
          if (out_ch.epoch_seconds !== want)
            report_mismatch($sformatf("epoch_seconds got %0d expected %0d",
                                      out_ch.epoch_seconds, want));
        end
      end
    end
    fail_count <= mismatches;
    pending    <= expected_epochs.size();
  end

endmodule

[sim/calendar_to_epoch_seconds_unit_test.sv]
module calendar_to_epoch_seconds_unit_test;
  import cte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdlePct      = 36;
  localparam int RandomDates  = 800;
  localparam int StallLimit   = 2000;
  localparam int HoldCycles   = 300;
  localparam int HoldAfter    = 300;
  localparam int QuietFirst   = 400;
  localparam int QuietLast    = 600;
  localparam int DrainCycles  = 20;

  logic        clk;
  logic        rst_n;
  int unsigned fail_count;
  int unsigned pending;
  bit          sender_quiet;

  cte_in_if  in_ch();
  cte_out_if out_ch();

  calendar_to_epoch_seconds_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  epoch_seconds_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic cte_req_t make_date(int yr, int mon, int day, int hr, int mn, int sc);
    cte_req_t d;
    d.years_since_1900 = yr[YearW-1:0];
    d.month_index      = mon[MonthW-1:0];
    d.day_of_month     = day[DayW-1:0];
    d.hour             = hr[HourW-1:0];
    d.minute           = mn[MinuteW-1:0];
    d.second           = sc[SecondW-1:0];
    return d;
  endfunction

  // Mostly legal dates, some with out-of-range fields
  function automatic cte_req_t random_date();
    int yr;
    int mon;
    yr  = ($urandom_range(9) == 0) ? $urandom_range(60, 520) : $urandom_range(0, 8191);
    mon = ($urandom_range(3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 11);
    return make_date(yr, mon,
      ($urandom_range(6) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 31),
      ($urandom_range(6) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 23),
      ($urandom_range(6) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 59),
      ($urandom_range(6) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 60));
  endfunction

  // Offer one beat, with random gaps in front, and wait for it to be taken
  task automatic send_date(input cte_req_t d);
    while (!sender_quiet && $urandom_range(99) < IdlePct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.years_since_1900 <= d.years_since_1900;
    in_ch.month_index      <= d.month_index;
    in_ch.day_of_month     <= d.day_of_month;
    in_ch.hour             <= d.hour;
    in_ch.minute           <= d.minute;
    in_ch.second           <= d.second;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Result side: random back-pressure, one long hold, a quiet stretch
  initial begin
    int unsigned n_taken;
    bit          held;
    n_taken = 0;
    held    = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) n_taken++;
      if (!held && n_taken >= HoldAfter) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        out_ch.ready <= (n_taken >= QuietFirst && n_taken < QuietLast) ||
                        ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // Watchdog: too long without any beat on either channel
  initial begin
    int unsigned idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // Reset, directed dates, random dates, drain, verdict
  initial begin
    sender_quiet = 1'b0;
    rst_n                  <= 1'b0;
    in_ch.valid            <= 1'b0;
    in_ch.years_since_1900 <= '0;
    in_ch.month_index      <= '0;
    in_ch.day_of_month     <= '0;
    in_ch.hour             <= '0;
    in_ch.minute           <= '0;
    in_ch.second           <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // epoch itself and one second before it
    send_date(make_date(70, 0, 1, 0, 0, 0));
    send_date(make_date(69, 11, 31, 23, 59, 59));
    // century rules: 1900 and 2100 common, 2000 leap, 2300 common, 2400 leap
    send_date(make_date(0, 0, 1, 0, 0, 0));
    send_date(make_date(0, 1, 29, 0, 0, 0));
    send_date(make_date(100, 1, 29, 12, 0, 0));
    send_date(make_date(100, 2, 1, 0, 0, 0));
    send_date(make_date(200, 2, 1, 0, 0, 0));
    send_date(make_date(400, 2, 1, 0, 0, 0));
    send_date(make_date(500, 2, 1, 0, 0, 0));
    send_date(make_date(124, 1, 29, 6, 30, 15));
    // extremes of every field
    send_date(make_date(8191, 127, 31, 31, 63, 63));
    send_date(make_date(0, -128, 0, 0, 0, 0));
    send_date(make_date(8099, 11, 31, 23, 59, 60));
    send_date(make_date(8100, -128, 31, 0, 0, 0));
    // month fold in both directions
    send_date(make_date(70, 12, 1, 0, 0, 0));
    send_date(make_date(70, -1, 1, 0, 0, 0));
    send_date(make_date(70, -12, 1, 0, 0, 0));
    send_date(make_date(70, -13, 1, 0, 0, 0));
    send_date(make_date(70, 11, 31, 0, 0, 0));
    send_date(make_date(5, 127, 15, 12, 30, 30));
    // day zero and unchecked time of day, leap second
    send_date(make_date(70, 0, 0, 0, 0, 0));
    send_date(make_date(70, 0, 1, 24, 60, 60));
    send_date(make_date(72, 0, 1, 0, 0, 60));

    for (int i = 0; i < RandomDates; i++) begin
      sender_quiet = (i >= QuietFirst && i < QuietLast);
      send_date(random_date());
    end
    in_ch.valid <= 1'b0;
    // let the checker count the last beat before looking at pending
    @(posedge clk);

    // wait out the pipeline, then a few more cycles for stray beats
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

[calendar_to_epoch_seconds_unit.f]
rtl/core/cte_pkg.sv
rtl/core/cte_in_if.sv
rtl/core/cte_out_if.sv
rtl/core/cte_month_fold.sv
rtl/core/cte_year_days.sv
rtl/core/cte_sec_scale.sv
rtl/core/calendar_to_epoch_seconds_unit.sv
sim/epoch_seconds_checker.sv
sim/calendar_to_epoch_seconds_unit_test.sv
